// ===== hw/rtl/bhpq_pkg.sv =====
package bhpq_pkg;

  // fixed widths of the external words
  localparam int IO_KEY_BITS = 32;
  localparam int COUNT_BITS  = 11;

  // action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_POP_HOLD,
    S_DN_L,
    S_DN_R,
    S_WR_HOLD,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/binary_heap_priority_queue.sv =====
// a push on an empty heap writes the key at the root; otherwise it reads and compares one parent
// per level on the way up, then writes the held key; a pop reads the root and the last entry,
// then reads one or both children per level on the way down and writes the held key at the hole
// rejected pushes and pops on an empty heap go straight to done; one word in flight at a time
// the result word goes valid at the edge that returns to idle, once the previous result is taken
// rst (synchronous) empties the heap and selects min order; the key memory is not cleared
module binary_heap_priority_queue
  import bhpq_pkg::*;
#(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic signed [IO_KEY_BITS-1:0] key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [IO_KEY_BITS-1:0] top_key,
  output logic                          popped_valid,
  output logic [1:0]                    status,
  output logic [COUNT_BITS-1:0]         entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;

  // key comparison under the selected order
  function automatic logic ranks_above(input logic [KEY_BITS-1:0] a,
                                       input logic [KEY_BITS-1:0] b,
                                       input logic om);
    logic res;
    res = om ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
    return res;
  endfunction

  state_t state, state_next;

  logic                   order_max;
  logic [NW-1:0]          count;
  logic [AW-1:0]          pos;
  logic [KEY_BITS-1:0]    hold;
  logic [KEY_BITS-1:0]    left_key;
  logic                   left_above_hold;

  logic [IO_KEY_BITS-1:0] res_top;
  logic                   res_popped;
  status_t                res_status;
  status_t                out_status;

  // key memory
  logic [KEY_BITS-1:0]    mem [CAPACITY];
  logic [KEY_BITS-1:0]    rd_data;
  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [KEY_BITS-1:0]    wr_data;

  logic                   accept, out_load;
  logic                   heap_full, heap_empty;
  logic [LW-1:0]          count_l, lc_l, rc_l, np_lc;
  logic [AW-1:0]          parent, best_pos, np;
  logic [KEY_BITS-1:0]    best_key;
  logic                   rc_ok, up_swap, r_above_l, r_above_h, l_above_h;
  logic                   dn_swap, desc_more;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_load   = (state == S_DONE) && (!out_valid || out_ready);
  assign heap_full  = (count == NW'(CAPACITY));
  assign heap_empty = (count == '0);

  // tree address arithmetic
  assign count_l = LW'(count);
  assign lc_l    = {1'b0, pos, 1'b1};
  assign rc_l    = lc_l + LW'(1);
  assign rc_ok   = (rc_l < count_l);
  assign parent  = (pos - AW'(1)) >> 1;

  // comparisons against the word coming out of memory
  assign up_swap   = ranks_above(hold, rd_data, order_max);
  assign l_above_h = ranks_above(rd_data, hold, order_max);
  assign r_above_l = ranks_above(rd_data, left_key, order_max);
  assign r_above_h = ranks_above(rd_data, hold, order_max);

  // better child and whether it moves up
  always_comb begin
    best_pos = lc_l[AW-1:0];
    best_key = rd_data;
    dn_swap  = l_above_h;
    if (state == S_DN_R) begin
      if (r_above_l) begin
        best_pos = rc_l[AW-1:0];
        best_key = rd_data;
        dn_swap  = r_above_h;
      end else begin
        best_pos = lc_l[AW-1:0];
        best_key = left_key;
        dn_swap  = left_above_hold;
      end
    end
  end

  // next hole position on the way down and whether it has a child
  assign np        = (state == S_POP_HOLD) ? '0 : best_pos;
  assign np_lc     = {1'b0, np, 1'b1};
  assign desc_more = (np_lc < count_l);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_PUSH) begin
            if (heap_full) begin
              state_next = S_DONE;
            end else if (heap_empty) begin
              state_next = S_WR_HOLD;
            end else begin
              state_next = S_UP_RD;
            end
          end else begin
            state_next = heap_empty ? S_DONE : S_POP_ROOT;
          end
        end
      end
      S_UP_RD:    state_next = S_UP_CMP;
      S_UP_CMP: begin
        state_next = (up_swap && parent != '0) ? S_UP_RD : S_WR_HOLD;
      end
      S_POP_ROOT: state_next = S_POP_LAST;
      S_POP_LAST: state_next = S_POP_HOLD;
      S_POP_HOLD: state_next = desc_more ? S_DN_L : S_WR_HOLD;
      S_DN_L: begin
        if (rc_ok) begin
          state_next = S_DN_R;
        end else begin
          state_next = (dn_swap && desc_more) ? S_DN_L : S_WR_HOLD;
        end
      end
      S_DN_R: begin
        state_next = (dn_swap && desc_more) ? S_DN_L : S_WR_HOLD;
      end
      S_WR_HOLD:  state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = hold;
    case (state)
      S_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = parent;
      end
      S_UP_CMP: begin
        if (up_swap) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
        end
      end
      S_POP_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_POP_LAST: begin
        rd_en   = 1'b1;
        rd_addr = AW'(count);
      end
      S_POP_HOLD: begin
        rd_en   = desc_more;
        rd_addr = np_lc[AW-1:0];
      end
      S_DN_L: begin
        if (rc_ok) begin
          rd_en   = 1'b1;
          rd_addr = rc_l[AW-1:0];
        end else if (dn_swap) begin
          wr_en   = 1'b1;
          wr_data = best_key;
          rd_en   = desc_more;
          rd_addr = np_lc[AW-1:0];
        end
      end
      S_DN_R: begin
        if (dn_swap) begin
          wr_en   = 1'b1;
          wr_data = best_key;
          rd_en   = desc_more;
          rd_addr = np_lc[AW-1:0];
        end
      end
      S_WR_HOLD: begin
        wr_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // key memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      order_max <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        order_max <= cfg_data;
      end
      if (accept) begin
        if (action == ACT_PUSH && !heap_full) begin
          count <= count + NW'(1);
        end else if (action == ACT_POP && !heap_empty) begin
          count <= count - NW'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sift datapath and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      hold       <= KEY_BITS'(key);
      pos        <= AW'(count);
      res_top    <= '0;
      res_popped <= 1'b0;
      if (action == ACT_PUSH) begin
        res_status <= heap_full ? ST_FULL : ST_OK;
      end else begin
        res_status <= heap_empty ? ST_EMPTY : ST_OK;
      end
    end
    case (state)
      S_UP_CMP: begin
        if (up_swap) begin
          pos <= parent;
        end
      end
      S_POP_LAST: begin
        res_top    <= IO_KEY_BITS'(rd_data);
        res_popped <= 1'b1;
      end
      S_POP_HOLD: begin
        hold <= rd_data;
        pos  <= '0;
      end
      S_DN_L: begin
        left_key        <= rd_data;
        left_above_hold <= l_above_h;
        if (!rc_ok && dn_swap) begin
          pos <= best_pos;
        end
      end
      S_DN_R: begin
        if (dn_swap) begin
          pos <= best_pos;
        end
      end
      default: begin
        left_key <= left_key;
      end
    endcase
    if (out_load) begin
      top_key      <= res_top;
      popped_valid <= res_popped;
      out_status   <= res_status;
      entry_count  <= COUNT_BITS'(count);
    end
  end

  assign status = out_status;

`ifndef SYNTHESIS
  // the fill count never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(CAPACITY))
    else $error("fill count beyond capacity");

  // a sift never reads the entry it writes in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write of the same entry in one cycle");

  // a popped key always comes with an ok status
  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && popped_valid) |-> (out_status == ST_OK))
    else $error("popped word with error status");

  // a pop on an empty heap leaves it empty
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_POP && heap_empty) |=> (count == '0))
    else $error("pop on empty heap changed the fill count");
`endif

endmodule
